// ===== rtl/vlkc_pkg.sv =====
// shared types, codes and the volume ladder for the volume ladder key control
package vlkc_pkg;

    localparam int VOL_W      = 9;
    localparam int WVAL_W     = 11;
    localparam int RUNG_COUNT = 13;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 16;
    localparam int M_USER_W   = 2;

    typedef logic [VOL_W-1:0] vol_t;

    localparam vol_t VOLUME_UNITY   = 9'd256;
    localparam vol_t DEFAULT_VOLUME = 9'd128;
    localparam vol_t FALLBACK_RESET = 9'd128;

    // 3 dB rungs, unity last
    localparam vol_t LADDER [RUNG_COUNT] = '{
        9'd4, 9'd6, 9'd8, 9'd11, 9'd16, 9'd23, 9'd32, 9'd45,
        9'd64, 9'd91, 9'd128, 9'd181, VOLUME_UNITY
    };

    typedef enum logic
    {
        OP_KEY   = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        KEY_OTHER = 2'd0,
        KEY_UP    = 2'd1,
        KEY_DOWN  = 2'd2,
        KEY_MUTE  = 2'd3
    } key_code_t;

endpackage

// ===== rtl/volume_ladder_key_control.sv =====
// master volume controller: ladder steps, mute toggle and direct writes
//
// Usage:
//   s_axis carries one item per handshake: tuser holds the opcode (key event
//   or direct write), tdata holds key_code, pressed and write_value. m_axis
//   returns exactly one result item per input item, in order: tdata holds
//   volume_now, tuser holds consumed and changed.
//   cfg_we/cfg_wdata write unmute_fallback; write it only while idle.
// Flow and throughput:
//   an accepted item lands in an input register, is worked out in one pass
//   of compare and select logic against the held volume state and goes into
//   the result register when the output side can advance; tvalid then rises.
//   One item per cycle is sustained while m_axis_tready stays high; the 13-rung compare is the only path.
// Reset:
//   volume 128, nothing remembered, fallback 128, both channels empty.
// Stall:
//   when m_axis_tready is low the result holds; one more item can wait in
//   the input register, after which s_axis_tready drops until the result
//   is taken.
module volume_ladder_key_control
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vlkc_pkg::VOL_W-1:0]    cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] key_code, [2] pressed, [13:3] write_value, [15:14] zero
    input  logic [vlkc_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] opcode
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [8:0] volume_now, [15:9] zero
    output logic [vlkc_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [0] consumed, [1] changed
    output logic [vlkc_pkg::M_USER_W-1:0] m_axis_tuser
);
    import vlkc_pkg::*;

    logic               in_valid_reg;
    opcode_t            in_op_reg;
    key_code_t          in_key_reg;
    logic               in_pressed_reg;
    logic [WVAL_W-1:0]  in_wval_reg;

    logic               out_valid_reg;
    vol_t               out_volume_reg;
    logic               out_consumed_reg;
    logic               out_changed_reg;

    vol_t               volume_reg;
    vol_t               volume_next;
    vol_t               premute_reg;
    vol_t               premute_next;
    vol_t               fallback_reg;

    logic               consumed_next;
    logic               changed_next;
    vol_t               step_up;
    vol_t               step_down;
    vol_t               step_n;
    vol_t               fallback_clamped;
    logic               advance;
    logic               in_accept;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign fallback_clamped = (fallback_reg > VOLUME_UNITY) ? VOLUME_UNITY : fallback_reg;

    // lowest rung above and highest rung below the current volume
    always_comb
    begin
        step_up   = VOLUME_UNITY;
        step_down = '0;
        for (int i = RUNG_COUNT - 1; i >= 0; i--)
        begin
            if (LADDER[i] > volume_reg)
            begin
                step_up = LADDER[i];
            end
        end
        for (int j = 0; j < RUNG_COUNT; j++)
        begin
            if (LADDER[j] < volume_reg)
            begin
                step_down = LADDER[j];
            end
        end
    end

    always_comb
    begin
        volume_next   = volume_reg;
        premute_next  = premute_reg;
        consumed_next = 1'b0;
        changed_next  = 1'b0;
        step_n        = (in_key_reg == KEY_UP) ? step_up : step_down;
        unique case (in_op_reg)
            OP_WRITE:
            begin
                changed_next = 1'b1;
                if (in_wval_reg[WVAL_W-1])
                begin
                    volume_next = '0;
                end
                else if (in_wval_reg[WVAL_W-2:0] > {1'b0, VOLUME_UNITY})
                begin
                    volume_next = VOLUME_UNITY;
                end
                else
                begin
                    volume_next = in_wval_reg[VOL_W-1:0];
                end
            end
            OP_KEY:
            begin
                if (in_key_reg != KEY_OTHER)
                begin
                    consumed_next = 1'b1;
                    if (in_pressed_reg)
                    begin
                        changed_next = 1'b1;
                        unique case (in_key_reg)
                            KEY_UP, KEY_DOWN:
                            begin
                                volume_next = step_n;
                                if (step_n == '0 && volume_reg != '0)
                                begin
                                    premute_next = volume_reg;
                                end
                                else if (step_n != '0)
                                begin
                                    premute_next = '0;
                                end
                            end
                            KEY_MUTE:
                            begin
                                if (volume_reg != '0)
                                begin
                                    premute_next = volume_reg;
                                    volume_next  = '0;
                                end
                                else
                                begin
                                    premute_next = '0;
                                    volume_next  = (premute_reg != '0) ? premute_reg
                                                                        : fallback_clamped;
                                end
                            end
                            default:
                            begin
                                volume_next = volume_reg;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                volume_next = volume_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            volume_reg    <= DEFAULT_VOLUME;
            premute_reg   <= '0;
            fallback_reg  <= FALLBACK_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                fallback_reg <= cfg_wdata;
            end
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    volume_reg  <= volume_next;
                    premute_reg <= premute_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg      <= opcode_t'(s_axis_tuser);
            in_key_reg     <= key_code_t'(s_axis_tdata[1:0]);
            in_pressed_reg <= s_axis_tdata[2];
            in_wval_reg    <= s_axis_tdata[13:3];
        end
        if (advance && in_valid_reg)
        begin
            out_volume_reg   <= volume_next;
            out_consumed_reg <= consumed_next;
            out_changed_reg  <= changed_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - VOL_W){1'b0}}, out_volume_reg};
    assign m_axis_tuser  = {out_changed_reg, out_consumed_reg};

    // volume state never leaves the 0..unity range
    a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
        volume_reg <= VOLUME_UNITY)
        else $error("master volume above unity");

    // a waiting result always shows the current volume state
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_volume_reg == volume_reg))
        else $error("pending result differs from volume state");

    // input side only stalls when both stages are full and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    // a key release never reports a change
    a_release_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && in_op_reg == OP_KEY && !in_pressed_reg)
            |=> (out_valid_reg && !out_changed_reg))
        else $error("key release reported a change");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the volume ladder key control block
module testbench;

    import vlkc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int LONG_HOLD = 200;

    typedef struct packed
    {
        opcode_t                  op;
        key_code_t                key;
        logic                     pressed;
        logic signed [WVAL_W-1:0] wval;
    } vol_item_t;

    typedef struct packed
    {
        logic consumed;
        vol_t volume;
        logic changed;
    } vol_result_t;

    // 3 dB rungs, unity last
    localparam vol_t RUNGS [RUNG_COUNT] = '{
        9'd4, 9'd6, 9'd8, 9'd11, 9'd16, 9'd23, 9'd32, 9'd45,
        9'd64, 9'd91, 9'd128, 9'd181, 9'd256
    };
    localparam vol_t UNITY = 9'd256;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [VOL_W-1:0]    cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;

    vol_item_t   pending_items[$];
    vol_result_t expected_results[$];

    // predicted block state
    vol_t cur_volume = 9'd128;
    vol_t saved_volume = 9'd0;
    vol_t fallback_volume = 9'd128;

    int items_issued = 0;
    int results_done = 0;
    int error_count = 0;

    vol_item_t   offered_item;
    vol_result_t offered_want;
    int          burst_left = 0;
    int          gap_left = 0;

    int recv_taken = 0;
    int recv_hold = 0;
    int recv_mode = 0;
    int recv_mode_left = 0;

    volume_ladder_key_control uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at result %0d: got %0d, want %0d",
                 field, results_done, got, want);
        error_count++;
    endtask

    // advance the volume state by one item and return the result it gives
    task automatic predict_volume(input vol_item_t it, output vol_result_t res);
        int   w;
        vol_t v;
        vol_t n;
        vol_t back;
        res = '0;
        v = cur_volume;
        if (it.op == OP_WRITE)
        begin
            w = it.wval;
            if (w < 0)
                cur_volume = 9'd0;
            else if (w > int'(UNITY))
                cur_volume = UNITY;
            else
                cur_volume = vol_t'(w);
            res.changed = 1'b1;
        end
        else if (it.key != KEY_OTHER)
        begin
            res.consumed = 1'b1;
            if (it.pressed)
            begin
                res.changed = 1'b1;
                if (it.key == KEY_MUTE)
                begin
                    if (v > 0)
                    begin
                        saved_volume = v;
                        cur_volume = 9'd0;
                    end
                    else
                    begin
                        back = (saved_volume > 0) ? saved_volume : fallback_volume;
                        saved_volume = 9'd0;
                        cur_volume = (back > UNITY) ? UNITY : back;
                    end
                end
                else
                begin
                    if (it.key == KEY_UP)
                    begin
                        // descending scan leaves the lowest rung above v
                        n = UNITY;
                        for (int i = RUNG_COUNT - 1; i >= 0; i--)
                            if (RUNGS[i] > v)
                                n = RUNGS[i];
                    end
                    else
                    begin
                        // ascending scan leaves the highest rung below v
                        n = 9'd0;
                        for (int i = 0; i < RUNG_COUNT; i++)
                            if (RUNGS[i] < v)
                                n = RUNGS[i];
                    end
                    if (n == 0 && v > 0)
                        saved_volume = v;
                    else if (n > 0)
                        saved_volume = 9'd0;
                    cur_volume = n;
                end
            end
        end
        res.volume = cur_volume;
    endtask

    task automatic push_item(input opcode_t op, input key_code_t key, input logic pressed,
                             input int wval);
        vol_item_t it;
        it.op = op;
        it.key = key;
        it.pressed = pressed;
        it.wval = wval[WVAL_W-1:0];
        pending_items.push_back(it);
        items_issued++;
    endtask

    task automatic push_random_item();
        int pick;
        int wsel;
        int wval;
        wval = $urandom_range(0, 2047);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            push_item(OP_KEY, KEY_UP, 1'b1, wval);
        else if (pick < 60)
            push_item(OP_KEY, KEY_DOWN, 1'b1, wval);
        else if (pick < 75)
            push_item(OP_KEY, KEY_MUTE, 1'b1, wval);
        else if (pick < 88)
        begin
            wsel = $urandom_range(0, 3);
            case (wsel)
                0: wval = $urandom_range(0, 2047);
                1: wval = $urandom_range(0, 256);
                2: wval = $urandom_range(0, 12);
                default: wval = $urandom_range(250, 300);
            endcase
            push_item(OP_WRITE, key_code_t'($urandom_range(0, 3)), 1'($urandom), wval);
        end
        else if (pick < 94)
            push_item(OP_KEY, key_code_t'($urandom_range(0, 3)), 1'b0, wval);
        else
            push_item(OP_KEY, KEY_OTHER, 1'($urandom), wval);
    endtask

    task automatic wait_idle();
        while (results_done != items_issued)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_fallback(input vol_t value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        fallback_volume = value;
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_volume(offered_item, offered_want);
                expected_results.push_back(offered_want);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    offered_item = pending_items.pop_front();
                    s_axis_tdata <= {2'b00, offered_item.wval, offered_item.pressed,
                                     offered_item.key};
                    s_axis_tuser <= offered_item.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(40, 100) : $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = $urandom_range(0, 8);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern in stretches, plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_taken = 0;
            recv_hold = 0;
            recv_mode = 0;
            recv_mode_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                recv_taken++;
                if (recv_taken == 150 || recv_taken == 450)
                    recv_hold = LONG_HOLD;
            end
            if (recv_mode_left == 0)
            begin
                recv_mode = $urandom_range(0, 3);
                recv_mode_left = $urandom_range(8, 64);
            end
            else
                recv_mode_left--;
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (recv_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // checker
    always @(posedge clk)
    begin
        vol_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", m_axis_tdata[VOL_W-1:0], -1);
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[VOL_W-1:0] !== want.volume)
                    report_mismatch("volume_now", m_axis_tdata[VOL_W-1:0], want.volume);
                if (m_axis_tuser[0] !== want.consumed)
                    report_mismatch("consumed", m_axis_tuser[0], want.consumed);
                if (m_axis_tuser[1] !== want.changed)
                    report_mismatch("changed", m_axis_tuser[1], want.changed);
                results_done++;
            end
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        vol_t fallback_list [6];
        fallback_list = '{9'd0, 9'd256, 9'd511, 9'd300, 9'd0, 9'd128};
        fallback_list[4] = vol_t'($urandom_range(1, 255));

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: releases, other keys, ladder ends, mute paths, write clamps
        push_item(OP_KEY, KEY_UP, 1'b0, 0);
        push_item(OP_KEY, KEY_OTHER, 1'b1, 2047);
        push_item(OP_KEY, KEY_OTHER, 1'b0, 1023);
        push_item(OP_KEY, KEY_UP, 1'b1, 1024);
        push_item(OP_KEY, KEY_UP, 1'b1, 0);
        push_item(OP_KEY, KEY_UP, 1'b1, 2047);
        push_item(OP_KEY, KEY_DOWN, 1'b1, 0);
        push_item(OP_WRITE, KEY_OTHER, 1'b0, 0);
        push_item(OP_KEY, KEY_DOWN, 1'b1, 0);
        push_item(OP_KEY, KEY_UP, 1'b1, 0);
        push_item(OP_KEY, KEY_DOWN, 1'b1, 0);
        push_item(OP_KEY, KEY_MUTE, 1'b1, 0);
        push_item(OP_KEY, KEY_MUTE, 1'b1, 0);
        push_item(OP_KEY, KEY_MUTE, 1'b1, 0);
        push_item(OP_WRITE, KEY_MUTE, 1'b1, -1024);
        push_item(OP_KEY, KEY_MUTE, 1'b1, 0);
        push_item(OP_WRITE, KEY_UP, 1'b0, 1023);
        push_item(OP_WRITE, KEY_DOWN, 1'b1, 256);
        push_item(OP_WRITE, KEY_OTHER, 1'b1, 257);
        push_item(OP_WRITE, KEY_OTHER, 1'b0, 5);
        push_item(OP_KEY, KEY_DOWN, 1'b1, 0);
        push_item(OP_WRITE, KEY_OTHER, 1'b0, 3);
        push_item(OP_KEY, KEY_DOWN, 1'b1, 0);
        push_item(OP_KEY, KEY_MUTE, 1'b0, 0);
        push_item(OP_WRITE, KEY_OTHER, 1'b0, -1);
        wait_idle();

        // random phases, each under its own fallback setting
        foreach (fallback_list[p])
        begin
            write_fallback(fallback_list[p]);
            repeat (ITEMS_PER_PHASE) push_random_item();
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
